FILE: hw/rtl/pmtp_pkg.sv
// pmtp_pkg: widths, register indexes, codes and fixed-point constants of the
// polyline Mercator tile projector, plus elaboration-time math helpers.
// No dependencies.
`default_nettype none

package pmtp_pkg;

    localparam int LON_W    = 32;
    localparam int LAT_W    = 32;
    localparam int CLASS_W  = 2;
    localparam int COORD_W  = 11;
    localparam int COLOUR_W = 2;
    localparam int ZOOM_W   = 5;
    localparam int TILE_W   = 20;
    localparam int REG_IDX_W = 2;
    localparam int CFG_W    = 20;
    localparam int G_W      = 31;

    localparam logic [REG_IDX_W-1:0] REG_ZOOM_LEVEL  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_BASE_TILE_X = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BASE_TILE_Y = 2'd2;

    localparam logic [CLASS_W-1:0] CLASS_CLOSURE    = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_JAM        = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_CONGESTION = 2'd2;

    localparam logic [COLOUR_W-1:0] COLOUR_BLACK  = 2'd0;
    localparam logic [COLOUR_W-1:0] COLOUR_RED    = 2'd1;
    localparam logic [COLOUR_W-1:0] COLOUR_ORANGE = 2'd2;

    localparam logic [ZOOM_W-1:0] ZOOM_RESET = 5'd14;
    localparam logic [ZOOM_W-1:0] ZOOM_MAX   = 5'd20;

    localparam logic [63:0] ONE_Q30   = 64'd1073741824;
    localparam logic [63:0] PI_Q30    = 64'd3373259426;
    localparam longint      LN2_Q30   = 744261118;
    localparam logic [63:0] LAT_LIMIT = 64'd1014699490;

    // shift-subtract unsigned divide, truncating quotient
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = 64'd0;
        rem = 65'd0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // alternating series: sine when sine is set, cosine otherwise (Q30)
    function automatic logic [63:0] trig_series(input logic [63:0] x, input logic sine);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] n;
        longint      acc;
        x2   = (x * x) >> 30;
        term = sine ? x : ONE_Q30;
        n    = sine ? 64'd1 : 64'd0;
        acc  = 0;
        for (int k = 0; k < 20; k++)
        begin
            if (k[0])
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
            term = (term * x2) >> 30;
            term = div_u64(term, (n + 64'd1) * (n + 64'd2));
            n    = n + 64'd2;
        end
        return (acc > 0) ? 64'(acc) : 64'd1;
    endfunction

    // natural log of a positive Q30 value, Q30 result
    function automatic longint ln_q30(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] m;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] term;
        logic [63:0] sum;
        int          hb;
        v  = (v_in == 64'd0) ? 64'd1 : v_in;
        hb = 0;
        while (hb < 63 && (v >> (hb + 1)) != 64'd0)
            hb++;
        m    = (hb >= 30) ? (v >> (hb - 30)) : (v << (30 - hb));
        t    = div_u64((m - ONE_Q30) << 30, m + ONE_Q30);
        t2   = (t * t) >> 30;
        term = t;
        sum  = 64'd0;
        for (int j = 0; j < 12; j++)
        begin
            sum  = sum + div_u64(term, 64'(2 * j + 1));
            term = (term * t2) >> 30;
        end
        return longint'(hb - 30) * LN2_Q30 + longint'(sum << 1);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pmtp_vertex_if.sv
// pmtp_vertex_if: valid/ready channel carrying one polyline vertex per beat.
// Depends on pmtp_pkg.
`default_nettype none

interface pmtp_vertex_if;
    logic                                valid;
    logic                                ready;
    logic signed [pmtp_pkg::LON_W-1:0]   longitude;
    logic signed [pmtp_pkg::LAT_W-1:0]   latitude;
    logic                                new_shape;
    logic        [pmtp_pkg::CLASS_W-1:0] line_class;

    modport source (output valid, longitude, latitude, new_shape, line_class, input ready);
    modport sink   (input valid, longitude, latitude, new_shape, line_class, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pmtp_segment_if.sv
// pmtp_segment_if: valid/ready channel carrying one drawn segment per beat.
// Depends on pmtp_pkg.
`default_nettype none

interface pmtp_segment_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pmtp_pkg::COORD_W-1:0]  start_x;
    logic signed [pmtp_pkg::COORD_W-1:0]  start_y;
    logic signed [pmtp_pkg::COORD_W-1:0]  end_x;
    logic signed [pmtp_pkg::COORD_W-1:0]  end_y;
    logic        [pmtp_pkg::COLOUR_W-1:0] colour_code;
    logic                                 last_segment;

    modport source (output valid, start_x, start_y, end_x, end_y, colour_code, last_segment,
                    input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, colour_code, last_segment,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pmtp_lat_table.sv
// pmtp_lat_table: constant ROM of ln(tan(45 + lat/2)) / pi in Q30, built at
// elaboration; two registered read ports give adjacent entries. Depends on pmtp_pkg.
`default_nettype none

module pmtp_lat_table #(
    parameter int TABLE_BITS = 10
) (
    input  logic                      clk,
    input  logic                      enable,
    input  logic [TABLE_BITS-1:0]     index,
    output logic [pmtp_pkg::G_W-1:0]  low_entry,
    output logic [pmtp_pkg::G_W-1:0]  high_entry
);
    import pmtp_pkg::*;

    localparam int TableSize = (1 << TABLE_BITS) + 1;
    localparam int StepShift = 30 - TABLE_BITS;

    typedef logic [G_W-1:0] rom_t [TableSize];

    function automatic rom_t build_rom();
        rom_t        rom;
        logic [63:0] a;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] c;
        logic [63:0] g;
        logic [63:0] prev;
        longint      m;
        prev = 64'd0;
        for (int i = 0; i < TableSize; i++)
        begin
            a = 64'(i) << StepShift;
            if (a > LAT_LIMIT)
                a = LAT_LIMIT;
            x = (a * PI_Q30) >> 31;
            s = trig_series(x, 1'b1);
            c = trig_series(x, 1'b0);
            m = ln_q30(ONE_Q30 + s) - ln_q30(c);
            g = (m > 0) ? div_u64(64'(m) << 30, PI_Q30) : 64'd0;
            if (g > ONE_Q30)
                g = ONE_Q30;
            if (g < prev)
                g = prev;
            rom[i] = G_W'(g);
            prev   = g;
        end
        return rom;
    endfunction

    localparam rom_t Rom = build_rom();

    logic [TABLE_BITS:0] low_addr;
    logic [TABLE_BITS:0] high_addr;
    logic [G_W-1:0]      low_reg;
    logic [G_W-1:0]      high_reg;

    assign low_addr  = {1'b0, index};
    assign high_addr = low_addr + (TABLE_BITS + 1)'(1);

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            low_reg  <= Rom[low_addr];
            high_reg <= Rom[high_addr];
        end
    end

    assign low_entry  = low_reg;
    assign high_entry = high_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/polyline_mercator_tile_projector_unit.sv
// polyline_mercator_tile_projector_unit: Web Mercator projection of polyline
// vertices into a 3x3 tile window, three offset segments per vertex.
// Depends on pmtp_pkg, pmtp_vertex_if, pmtp_segment_if, pmtp_lat_table.
//
//   channel   dir  beat                                     handshake
//   vertex    in   longitude, latitude, new_shape, class    valid/ready
//   segment   out  start/end x/y, colour_code, last_seg     valid/ready
//   write_*   in   register index + data                    write_enable
//
// One vertex enters per cycle unless the output register still holds segments; a vertex
// that yields segments holds the output register for three beats, so the segment port
// then sets the rate. From vertex beat to first segment the pipe runs through the input
// register, table ROM read, interpolation multiply, y shift and window check.
// Reset sets zoom 14, base tile 0 and forgets the previous vertex; the table is
// a constant ROM, so no fill is needed. A stalled segment port stalls the whole pipe.
`default_nettype none

module polyline_mercator_tile_projector_unit #(
    parameter int TILE_BITS     = 8,
    parameter int TABLE_BITS    = 10,
    parameter int WINDOW_OFFSET = 144
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             write_enable,
    input  logic [pmtp_pkg::REG_IDX_W-1:0]   write_index,
    input  logic [pmtp_pkg::CFG_W-1:0]       write_data,
    pmtp_vertex_if.sink                      vertex,
    pmtp_segment_if.source                   segment
);
    import pmtp_pkg::*;

    localparam int StepShift = 30 - TABLE_BITS;
    localparam int XpixW     = TILE_W + TILE_BITS;
    localparam int YpixW     = TILE_W + TILE_BITS + 1;
    localparam int ProdW     = G_W + StepShift;
    localparam int DiffW     = TILE_W + 2;

    localparam logic [COORD_W-1:0] Offset = COORD_W'(WINDOW_OFFSET);
    localparam logic [31:0]        One32  = 32'(ONE_Q30);
    localparam logic [31:0]        Limit32 = 32'(LAT_LIMIT);

    // configuration
    logic [ZOOM_W-1:0] zoom_reg;
    logic [TILE_W-1:0] base_x_reg;
    logic [TILE_W-1:0] base_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zoom_reg   <= ZOOM_RESET;
            base_x_reg <= '0;
            base_y_reg <= '0;
        end
        else if (write_enable)
        begin
            case (write_index)
                REG_ZOOM_LEVEL:  zoom_reg   <= write_data[ZOOM_W-1:0];
                REG_BASE_TILE_X: base_x_reg <= write_data[TILE_W-1:0];
                REG_BASE_TILE_Y: base_y_reg <= write_data[TILE_W-1:0];
                default: ;
            endcase
        end
    end

    logic [ZOOM_W-1:0] zoom_sat;
    logic [5:0]        shift_amt;

    assign zoom_sat  = (zoom_reg > ZOOM_MAX) ? ZOOM_MAX : zoom_reg;
    assign shift_amt = {1'b0, zoom_sat} + 6'(TILE_BITS);

    // pipeline control
    logic adv;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic out_valid_reg;
    logic first_reg;
    logic last_reg;

    assign adv          = !out_valid_reg || (segment.ready && last_reg);
    assign vertex.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= vertex.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // stage 1: x pixel, latitude magnitude and table index
    logic [31:0]           ulon;
    logic [31:0]           xpix_wide;
    logic [XpixW-1:0]      xpix_next;
    logic [31:0]           lat_abs;
    logic [29:0]           lat_mag;
    logic [COLOUR_W-1:0]   colour_next;

    assign ulon      = {~vertex.longitude[31], vertex.longitude[30:0]};
    assign xpix_wide = ulon >> (6'd32 - shift_amt);
    assign xpix_next = XpixW'(xpix_wide);
    assign lat_abs   = vertex.latitude[31] ? (32'd0 - vertex.latitude) : vertex.latitude;
    assign lat_mag   = (lat_abs > Limit32) ? 30'(Limit32) : lat_abs[29:0];

    always_comb
    begin
        case (vertex.line_class)
            CLASS_CLOSURE:    colour_next = COLOUR_BLACK;
            CLASS_JAM:        colour_next = COLOUR_RED;
            CLASS_CONGESTION: colour_next = COLOUR_ORANGE;
            default:          colour_next = COLOUR_BLACK;
        endcase
    end

    logic [XpixW-1:0]      xpix1_reg, xpix2_reg, xpix3_reg, xpix4_reg;
    logic [TABLE_BITS-1:0] idx1_reg;
    logic [StepShift-1:0]  frac1_reg, frac2_reg;
    logic                  neg1_reg, neg2_reg, neg3_reg;
    logic                  shape1_reg, shape2_reg, shape3_reg, shape4_reg;
    logic [COLOUR_W-1:0]   colour1_reg, colour2_reg, colour3_reg, colour4_reg;
    logic [G_W-1:0]        low3_reg;
    logic [G_W-1:0]        delta3_reg;
    logic [YpixW-1:0]      ypix4_reg;

    // stage 2: table entries
    logic [G_W-1:0] low_entry;
    logic [G_W-1:0] high_entry;

    pmtp_lat_table #(
        .TABLE_BITS (TABLE_BITS)
    ) u_lat_table (
        .clk        (clk),
        .enable     (adv),
        .index      (idx1_reg),
        .low_entry  (low_entry),
        .high_entry (high_entry)
    );

    // stage 3: interpolation product
    logic [ProdW-1:0] product_next;
    logic [G_W-1:0]   delta_next;

    assign product_next = ProdW'(high_entry - low_entry) * ProdW'(frac2_reg);
    assign delta_next   = product_next[ProdW-1:StepShift];

    // stage 4: y pixel
    logic [G_W-1:0]   merc_next;
    logic [31:0]      norm_next;
    logic [31:0]      ypix_wide;
    logic [YpixW-1:0] ypix_next;

    assign merc_next = low3_reg + delta3_reg;
    assign norm_next = neg3_reg ? (One32 + {1'b0, merc_next}) : (One32 - {1'b0, merc_next});
    assign ypix_wide = norm_next >> (6'd31 - shift_amt);
    assign ypix_next = YpixW'(ypix_wide);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xpix1_reg   <= xpix_next;
            idx1_reg    <= lat_mag[29:StepShift];
            frac1_reg   <= lat_mag[StepShift-1:0];
            neg1_reg    <= vertex.latitude[31];
            shape1_reg  <= vertex.new_shape;
            colour1_reg <= colour_next;

            xpix2_reg   <= xpix1_reg;
            frac2_reg   <= frac1_reg;
            neg2_reg    <= neg1_reg;
            shape2_reg  <= shape1_reg;
            colour2_reg <= colour1_reg;

            xpix3_reg   <= xpix2_reg;
            low3_reg    <= low_entry;
            delta3_reg  <= delta_next;
            neg3_reg    <= neg2_reg;
            shape3_reg  <= shape2_reg;
            colour3_reg <= colour2_reg;

            xpix4_reg   <= xpix3_reg;
            ypix4_reg   <= ypix_next;
            shape4_reg  <= shape3_reg;
            colour4_reg <= colour3_reg;
        end
    end

    // stage 5: window check, previous vertex, segment load
    logic [DiffW-1:0]   dx;
    logic [DiffW-1:0]   dy;
    logic               in_window;
    logic [1:0]         col_off;
    logic [1:0]         row_off;
    logic [COORD_W-1:0] cx_next;
    logic [COORD_W-1:0] cy_next;
    logic               prev_valid_reg;
    logic [COORD_W-1:0] prev_x_reg;
    logic [COORD_W-1:0] prev_y_reg;
    logic               prev_live;
    logic               emit;

    assign dx = {2'b00, xpix4_reg[XpixW-1:TILE_BITS]} - {2'b00, base_x_reg};
    assign dy = {1'b0, ypix4_reg[YpixW-1:TILE_BITS]} - {2'b00, base_y_reg};

    assign in_window = (dx == '0 || dx == DiffW'(1) || dx == '1) &&
                       (dy == '0 || dy == DiffW'(1) || dy == '1);

    assign col_off = dx[1:0] + 2'd1;
    assign row_off = dy[1:0] + 2'd1;
    assign cx_next = COORD_W'({col_off, xpix4_reg[TILE_BITS-1:0]});
    assign cy_next = COORD_W'({row_off, ypix4_reg[TILE_BITS-1:0]});

    assign prev_live = prev_valid_reg && !shape4_reg;
    assign emit      = s4_valid_reg && in_window && prev_live;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_valid_reg <= 1'b0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
        end
        else if (adv && s4_valid_reg)
        begin
            if (in_window)
            begin
                prev_valid_reg <= 1'b1;
                prev_x_reg     <= cx_next;
                prev_y_reg     <= cy_next;
            end
            else
            begin
                prev_valid_reg <= prev_live;
            end
        end
    end

    // output register: three beats per drawn vertex
    logic [COORD_W-1:0]  start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic [COLOUR_W-1:0] colour_reg;
    logic [COORD_W-1:0]  step;

    assign step = first_reg ? COORD_W'(1) : (COORD_W'(0) - COORD_W'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            first_reg     <= 1'b0;
            last_reg      <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= emit;
            first_reg     <= 1'b1;
            last_reg      <= 1'b0;
        end
        else if (segment.ready)
        begin
            first_reg <= 1'b0;
            last_reg  <= !first_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            start_x_reg <= prev_x_reg - Offset;
            start_y_reg <= prev_y_reg - Offset;
            end_x_reg   <= cx_next - Offset;
            end_y_reg   <= cy_next - Offset;
            colour_reg  <= colour4_reg;
        end
        else if (segment.ready)
        begin
            start_x_reg <= start_x_reg + step;
            start_y_reg <= start_y_reg + step;
            end_x_reg   <= end_x_reg + step;
            end_y_reg   <= end_y_reg + step;
        end
    end

    assign segment.valid        = out_valid_reg;
    assign segment.start_x      = start_x_reg;
    assign segment.start_y      = start_y_reg;
    assign segment.end_x        = end_x_reg;
    assign segment.end_y        = end_y_reg;
    assign segment.colour_code  = colour_reg;
    assign segment.last_segment = last_reg;

endmodule

`default_nettype wire
